/* hdl/bcf_pkg.sv */
// Shared types, constants and the alphabet lookup for the base32 code formatter.
package bcf_pkg;

  localparam int unsigned MAX_SYMS = 5;
  localparam logic [7:0] DASH_CHAR = 8'h2D;
  localparam logic [8*32-1:0] ALPHA_STR = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

  typedef enum logic {
    REG_GROUP_SIZE   = 1'b0,
    REG_APPEND_CHECK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]                  cnt;
    logic                        last;
    logic [MAX_SYMS-1:0][4:0]    syms;
  } bcf_list_t;

  function automatic logic [7:0] alpha_char(input logic [4:0] sym);
    alpha_char = ALPHA_STR[{~sym, 3'b000} +: 8];
  endfunction

endpackage

/* hdl/bcf_decode.sv */
// Input word register, bit carry state and symbol list extraction.
module bcf_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              append_check,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [9:0]        check_value,
  output logic              list_valid,
  input  logic              list_take,
  output bcf_pkg::bcf_list_t list
);
  import bcf_pkg::*;

  logic       item_valid_r, item_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic [9:0] check_r;
  logic [3:0] acc_r, acc_nxt;
  logic [2:0] pend_r, pend_nxt;

  logic        accept;
  logic [3:0]  n_full, n;
  logic [11:0] word;
  logic        two;
  logic [2:0]  rem;
  logic [4:0]  mask;
  logic [3:0]  keep;
  logic [4:0]  s0, s1, pad;
  logic [4:0][4:0] cand;
  logic [4:0]  en;

  assign in_tready  = !item_valid_r || list_take;
  assign accept     = in_tvalid && in_tready;
  assign list_valid = item_valid_r;

  always_comb begin
    n_full = {1'b0, pend_r} + 4'd8;
    n      = (n_full > 4'd12) ? 4'd12 : n_full;
    word   = {acc_r, byte_r};
    two    = (n >= 4'd10);
    s0     = 5'(word >> (n - 4'd5));
    s1     = 5'(word >> (n - 4'd10));
    rem    = two ? 3'(n - 4'd10) : 3'(n - 4'd5);
    mask   = (5'd1 << rem) - 5'd1;
    keep   = word[3:0] & mask[3:0];
    pad    = 5'({1'b0, keep} << (3'd5 - rem));
    cand   = {check_r[4:0], check_r[9:5], pad, s1, s0};
    en     = {last_r && append_check, last_r && append_check,
              last_r && (rem != 3'd0), two, 1'b1};
    list   = '0;
    list.last = last_r;
    for (int i = 0; i < MAX_SYMS; i++) begin
      if (en[i]) begin
        list.syms[list.cnt] = cand[i];
        list.cnt = list.cnt + 3'd1;
      end
    end
  end

  always_comb begin
    item_valid_nxt = item_valid_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    if (list_take) begin
      item_valid_nxt = 1'b0;
      acc_nxt        = last_r ? 4'd0 : keep;
      pend_nxt       = last_r ? 3'd0 : rem;
    end
    if (accept) begin
      item_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      acc_r        <= '0;
      pend_r       <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      acc_r        <= acc_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= data_byte;
      last_r  <= last_byte;
      check_r <= check_value;
    end
  end

endmodule

/* hdl/bcf_emit.sv */
// Symbol sequencer with dash insertion and the output word register.
module bcf_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        group_size,
  input  logic              list_valid,
  output logic              list_take,
  input  bcf_pkg::bcf_list_t list,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_char,
  output logic              last_char
);
  import bcf_pkg::*;

  logic [MAX_SYMS-1:0][4:0] syms_r, syms_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic       last_r, last_nxt;
  logic [3:0] gpos_r, gpos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic out_adv, busy, need_dash, emit_sym, final_sym;

  assign out_adv   = !out_valid_r || out_tready;
  assign busy      = (rem_r != 3'd0);
  assign need_dash = (group_size != 4'd0) && (gpos_r >= group_size);
  assign emit_sym  = out_adv && busy && !need_dash;
  assign final_sym = last_r && (rem_r == 3'd1);
  assign list_take = list_valid && (!busy || ((rem_r == 3'd1) && emit_sym));

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign last_char  = out_last_r;

  always_comb begin
    syms_nxt      = syms_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    gpos_nxt      = gpos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_adv) begin
      out_valid_nxt = busy;
      if (busy && need_dash) begin
        out_char_nxt = DASH_CHAR;
        out_last_nxt = 1'b0;
        gpos_nxt     = 4'd0;
      end else if (busy) begin
        out_char_nxt = alpha_char(syms_r[0]);
        out_last_nxt = final_sym;
        if (final_sym) begin
          gpos_nxt = 4'd0;
        end else if (gpos_r != 4'd15) begin
          gpos_nxt = gpos_r + 4'd1;
        end
        syms_nxt = {5'd0, syms_r[MAX_SYMS-1:1]};
        rem_nxt  = rem_r - 3'd1;
      end
    end
    if (list_take) begin
      syms_nxt = list.syms;
      rem_nxt  = list.cnt;
      last_nxt = list.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      last_r      <= 1'b0;
      gpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      last_r      <= last_nxt;
      gpos_r      <= gpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    syms_r     <= syms_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* hdl/base32_code_formatter_unit.sv */
// Top level of the base32 code formatter: config registers, decode and emit stages.
//
//   channel | dir | words                     | accept
//   in_*    | in  | one secret byte           | in_tvalid && in_tready
//   out_*   | out | one ASCII character       | out_tvalid && out_tready
//   cfg_*   | in  | register write, no wait   | cfg_we
//
// The output register delivers one character per cycle while out_tready is high; a byte
// yields 1 to 10 characters, one per symbol and dash it produces, typically about two.
// The input register takes the next byte while the previous one is still emitted.
// Reset is synchronous: clears state, group_size to 6, append_check to 1.
// A low out_tready holds the output word; input stalls once the byte register is full.
module base32_code_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [17:8] check_value, [23:18] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata
);
  import bcf_pkg::*;

  logic [3:0] group_size_r, group_size_nxt;
  logic       append_check_r, append_check_nxt;
  logic       list_valid, list_take;
  bcf_list_t  list;

  always_comb begin
    group_size_nxt   = group_size_r;
    append_check_nxt = append_check_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_GROUP_SIZE:   group_size_nxt   = cfg_wdata;
        REG_APPEND_CHECK: append_check_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r   <= 4'd6;
      append_check_r <= 1'b1;
    end else begin
      group_size_r   <= group_size_nxt;
      append_check_r <= append_check_nxt;
    end
  end

  bcf_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .append_check (append_check_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .data_byte    (in_tdata[7:0]),
    .last_byte    (in_tlast),
    .check_value  (in_tdata[17:8]),
    .list_valid   (list_valid),
    .list_take    (list_take),
    .list         (list)
  );

  bcf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .group_size (group_size_r),
    .list_valid (list_valid),
    .list_take  (list_take),
    .list       (list),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .last_char  (out_tlast)
  );

  a_last_not_dash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata != DASH_CHAR)
    else $error("final character is a dash");

  a_no_double_dash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == DASH_CHAR
      |=> !(out_tvalid && out_tdata == DASH_CHAR))
    else $error("two dashes in a row");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    list_valid |-> list.cnt != 3'd0)
    else $error("byte decoded to no symbols");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
